// ===== design/icv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types, constants and MOD-97 helpers for the IBAN checksum validator.
// ----------------------------------------------------------------------------
package icv_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned REM_W    = 7;
    localparam int unsigned VAL_W    = 6;
    localparam int unsigned FOLD_W   = 14;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 6;

    localparam logic [FOLD_W-1:0] MOD_BASE    = 14'd97;
    // floor(2^16 / 97), quotient estimate is low by at most one
    localparam logic [9:0]        RECIP_97    = 10'd675;
    localparam logic [FOLD_W-1:0] DEC_BASE    = 14'd10;
    localparam logic [FOLD_W-1:0] DEC_BASE_SQ = 14'd100;

    localparam logic [LEN_W-1:0]  COUNT_MAX   = 6'd63;
    localparam logic [LEN_W-1:0]  HEAD_DEPTH  = 6'd4;
    localparam logic [LEN_W-1:0]  COUNTRY_LEN = 6'd2;
    localparam logic [LEN_W-1:0]  MIN_LEN_RST = 6'd15;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 6'd34;
    localparam logic [REM_W-1:0]  REM_GOOD    = 7'd1;
    localparam logic [REM_W-1:0]  POW_ONE     = 7'd1;

    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UP_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHR_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LO_Z    = 8'h7A;
    localparam logic [VAL_W-1:0]  LETTER_OFS  = 6'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH = 1'b0,
        CFG_MAX_LENGTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_COUNTRY  = 3'd2,
        ERR_ILLEGAL  = 3'd3,
        ERR_CHECKSUM = 3'd4
    } t_err_code;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_in_beat;

    typedef struct packed {
        logic              valid_res;
        logic [2:0]        error_code;
        logic [LEN_W-1:0]  kept_length;
    } t_out_beat;

    // end-of-string view of the accumulator
    typedef struct packed {
        logic [REM_W-1:0] rem;       // remainder of characters five onward
        logic [REM_W-1:0] pow;       // 10^(head digits) mod 97
        logic [REM_W-1:0] head_rem;  // remainder of the held head digits
        logic [LEN_W-1:0] kept_length;
        logic             country_bad;
        logic             illegal_seen;
    } t_snap;

    // x mod 97 for x below 2^14: reciprocal estimate plus one correction
    function automatic logic [REM_W-1:0] mod97(input logic [FOLD_W-1:0] x);
        logic [23:0]       prod;
        logic [7:0]        q;
        logic [FOLD_W-1:0] r;
        prod = 24'(x) * 24'(RECIP_97);
        q    = prod[23:16];
        r    = x - (14'(q) * MOD_BASE);
        if (r >= MOD_BASE) begin
            r = r - MOD_BASE;
        end
        return r[REM_W-1:0];
    endfunction

    // append one value as one decimal digit or two
    function automatic logic [REM_W-1:0] fold(input logic [REM_W-1:0] r,
                                              input logic [VAL_W-1:0] v,
                                              input logic            two_digit);
        logic [FOLD_W-1:0] x;
        if (two_digit) begin
            x = 14'(r) * DEC_BASE_SQ + 14'(v);
        end else begin
            x = 14'(r) * DEC_BASE + 14'(v);
        end
        return mod97(x);
    endfunction

endpackage

// ===== design/icv_string_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_string_acc
// Per-string accumulator: classifies one character, folds it into the
// running remainders and presents the updated string state.
// ----------------------------------------------------------------------------
module icv_string_acc
    import icv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_beat i_beat,
    output t_snap    o_snap
);

    logic [REM_W-1:0] r_rem, n_rem;
    logic [REM_W-1:0] r_pow, n_pow;
    logic [REM_W-1:0] r_head_rem, n_head_rem;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_country_bad, n_country_bad;
    logic             r_illegal, n_illegal;

    logic             is_sep;
    logic             is_digit;
    logic             is_upper;
    logic             is_lower;
    logic             is_letter;
    logic [VAL_W-1:0] val;
    logic [CHAR_W-1:0] c;

    assign c = i_beat.char_code;

    always_comb begin
        is_sep    = (c == CHR_SPACE) || (c == CHR_DASH);
        is_digit  = (c >= CHR_ZERO) && (c <= CHR_NINE);
        is_upper  = (c >= CHR_UP_A) && (c <= CHR_UP_Z);
        is_lower  = (c >= CHR_LO_A) && (c <= CHR_LO_Z);
        is_letter = is_upper || is_lower;

        if (is_digit) begin
            val = 6'(c - CHR_ZERO);
        end else if (is_upper) begin
            val = 6'(c - CHR_UP_A) + LETTER_OFS;
        end else if (is_lower) begin
            val = 6'(c - CHR_LO_A) + LETTER_OFS;
        end else begin
            val = '0;
        end

        n_rem         = r_rem;
        n_pow         = r_pow;
        n_head_rem    = r_head_rem;
        n_count       = r_count;
        n_country_bad = r_country_bad;
        n_illegal     = r_illegal;

        if (!is_sep) begin
            if (!is_digit && !is_letter) begin
                n_illegal = 1'b1;
            end
            if ((r_count < COUNTRY_LEN) && !is_letter) begin
                n_country_bad = 1'b1;
            end
            if (r_count < HEAD_DEPTH) begin
                // head folds even an illegal char, as digit zero
                n_head_rem = fold(r_head_rem, val, is_letter);
                n_pow      = fold(r_pow, '0, is_letter);
            end else if (is_digit || is_letter) begin
                n_rem = fold(r_rem, val, is_letter);
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 6'd1;
            end
        end
    end

    always_comb begin
        o_snap.rem          = n_rem;
        o_snap.pow          = n_pow;
        o_snap.head_rem     = n_head_rem;
        o_snap.kept_length  = n_count;
        o_snap.country_bad  = n_country_bad;
        o_snap.illegal_seen = n_illegal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.last)) begin
            r_rem         <= '0;
            r_pow         <= POW_ONE;
            r_head_rem    <= '0;
            r_count       <= '0;
            r_country_bad <= 1'b0;
            r_illegal     <= 1'b0;
        end else if (i_step) begin
            r_rem         <= n_rem;
            r_pow         <= n_pow;
            r_head_rem    <= n_head_rem;
            r_count       <= n_count;
            r_country_bad <= n_country_bad;
            r_illegal     <= n_illegal;
        end
    end

endmodule

// ===== design/iban_checksum_validator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iban_checksum_validator_core
// Streaming IBAN validator: MOD-97-10 check, length, country and character
// checks, one result beat per string.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per input beat and accepts a beat in
// every cycle unless stalled. Spaces and dashes are dropped; others are kept
// and counted (saturating at 63). The first four kept characters are folded
// into a separate head remainder along with their digit weight, so the
// ISO 7064 rearrangement costs a single multiply-add at the end instead of
// refolding stored characters. A beat with last set closes the string and
// produces one result beat through its stages: input register, accumulator
// step, multiply-add of the head into the body remainder, then the final
// mod 97 and error priority (length, country, illegal char, checksum).
// The accumulator clears as the last beat is taken, so the next string may
// follow in the very next cycle. Ready to the input is combinational from
// the output ready through the four stage valids. min_length and max_length
// should only be written while no string is in flight.
// ----------------------------------------------------------------------------
module iban_checksum_validator_core
    import icv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // character beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic [LEN_W-1:0] r_min_len;
    logic [LEN_W-1:0] r_max_len;

    // input register
    logic     r_in_valid;
    t_in_beat r_in_beat;

    // end-of-string snapshot
    logic  r_snap_valid;
    t_snap r_snap;
    t_snap acc_snap;

    // head weighting stage
    logic              r_prod_valid;
    logic [FOLD_W-1:0] r_prod;
    t_err_code         r_pre_err;
    logic [LEN_W-1:0]  r_prod_len;
    logic [FOLD_W-1:0] n_prod;
    t_err_code         n_pre_err;

    // result register
    logic      r_out_valid;
    t_out_beat r_out_beat;
    t_out_beat n_out_beat;

    logic      out_free;
    logic      prod_free;
    logic      snap_free;
    logic      step;
    logic [REM_W-1:0] final_rem;
    t_err_code final_err;

    // stall chain, each stage loads when the one after it can move
    assign out_free  = !r_out_valid  || i_out_ready;
    assign prod_free = !r_prod_valid || out_free;
    assign snap_free = !r_snap_valid || prod_free;
    assign o_in_ready = !r_in_valid  || snap_free;
    assign step = r_in_valid && snap_free;

    // ---- config ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_LENGTH: r_min_len <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_LENGTH: r_max_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    // ---- per-character accumulator ----
    icv_string_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_beat  (r_in_beat),
        .o_snap  (acc_snap)
    );

    // only a last beat hands a string to the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_free) begin
            r_snap_valid <= step && r_in_beat.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_beat.last) begin
            r_snap <= acc_snap;
        end
    end

    // ---- head moved behind body: rem * 10^k + head ----
    always_comb begin
        n_prod = 14'(r_snap.rem) * 14'(r_snap.pow) + 14'(r_snap.head_rem);
        if ((r_snap.kept_length < r_min_len) || (r_snap.kept_length > r_max_len)) begin
            n_pre_err = ERR_LENGTH;
        end else if (r_snap.country_bad || (r_snap.kept_length < COUNTRY_LEN)) begin
            n_pre_err = ERR_COUNTRY;
        end else if (r_snap.illegal_seen) begin
            n_pre_err = ERR_ILLEGAL;
        end else begin
            n_pre_err = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (prod_free) begin
            r_prod_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_free && r_snap_valid) begin
            r_prod     <= n_prod;
            r_pre_err  <= n_pre_err;
            r_prod_len <= r_snap.kept_length;
        end
    end

    // ---- final reduction and error priority ----
    always_comb begin
        final_rem = mod97(r_prod);
        if (r_pre_err != ERR_NONE) begin
            final_err = r_pre_err;
        end else if (final_rem != REM_GOOD) begin
            final_err = ERR_CHECKSUM;
        end else begin
            final_err = ERR_NONE;
        end
        n_out_beat.valid_res   = (final_err == ERR_NONE);
        n_out_beat.error_code  = 3'(final_err);
        n_out_beat.kept_length = r_prod_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_prod_valid) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== test/iban_checksum_validator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iban_checksum_validator_checker
// Watches the character, result and register ports of the IBAN validator.
// Keeps its own copy of the string state, works out the verdict for every
// closing character beat and compares each result beat against the oldest
// verdict still owed.
// ----------------------------------------------------------------------------
module iban_checksum_validator_checker
    import icv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_beat              i_in_beat,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_beat             i_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [VAL_W-1:0] head_vals [4];
    logic [LEN_W-1:0] kept_cnt;
    logic [REM_W-1:0] body_rem;
    logic             country_bad;
    logic             illegal_seen;
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] max_len;
    t_out_beat        owed_verdicts [$];
    int               fail_count;
    int               owed_cnt;

    assign o_fail_count = fail_count;
    assign o_pending    = owed_cnt;

    // r followed by v written as one or two decimal digits, mod 97
    function automatic logic [REM_W-1:0] append_mod97(input logic [REM_W-1:0] r,
                                                      input logic [VAL_W-1:0] v,
                                                      input logic             two_digit);
        int unsigned x;
        x = two_digit ? r * 100 + v : r * 10 + v;
        return REM_W'(x % MOD_BASE);
    endfunction

    function automatic void clear_string();
        for (int i = 0; i < 4; i++) begin
            head_vals[i] = '0;
        end
        kept_cnt     = '0;
        body_rem     = '0;
        country_bad  = 1'b0;
        illegal_seen = 1'b0;
    endfunction

    function automatic void predict_char(input t_in_beat b);
        logic [CHAR_W-1:0] c;
        logic [VAL_W-1:0]  v;
        logic              is_digit;
        logic              is_upper;
        logic              is_lower;
        logic              is_letter;
        logic [REM_W-1:0]  r;
        int                held;
        t_err_code         err;
        t_out_beat         verdict;
        c = b.char_code;
        if (c != CHR_SPACE && c != CHR_DASH) begin
            is_digit  = c >= CHR_ZERO && c <= CHR_NINE;
            is_upper  = c >= CHR_UP_A && c <= CHR_UP_Z;
            is_lower  = c >= CHR_LO_A && c <= CHR_LO_Z;
            is_letter = is_upper || is_lower;
            v = '0;
            if (is_digit) begin
                v = VAL_W'(c - CHR_ZERO);
            end else if (is_upper) begin
                v = LETTER_OFS + VAL_W'(c - CHR_UP_A);
            end else if (is_lower) begin
                v = LETTER_OFS + VAL_W'(c - CHR_LO_A);
            end else begin
                illegal_seen = 1'b1;
            end
            if (kept_cnt < COUNTRY_LEN && !is_letter) begin
                country_bad = 1'b1;
            end
            if (kept_cnt < HEAD_DEPTH) begin
                head_vals[kept_cnt[1:0]] = v;
            end else if (is_digit || is_letter) begin
                body_rem = append_mod97(body_rem, v, is_letter);
            end
            if (kept_cnt != COUNT_MAX) begin
                kept_cnt = kept_cnt + 1'b1;
            end
        end
        if (b.last) begin
            // head characters move behind the body
            r    = body_rem;
            held = kept_cnt < HEAD_DEPTH ? int'(kept_cnt) : 4;
            for (int i = 0; i < held; i++) begin
                r = append_mod97(r, head_vals[i], head_vals[i] >= LETTER_OFS);
            end
            if (kept_cnt < min_len || kept_cnt > max_len) begin
                err = ERR_LENGTH;
            end else if (country_bad || kept_cnt < COUNTRY_LEN) begin
                err = ERR_COUNTRY;
            end else if (illegal_seen) begin
                err = ERR_ILLEGAL;
            end else if (r != REM_GOOD) begin
                err = ERR_CHECKSUM;
            end else begin
                err = ERR_NONE;
            end
            verdict.valid_res   = err == ERR_NONE;
            verdict.error_code  = err;
            verdict.kept_length = kept_cnt;
            owed_verdicts.push_back(verdict);
            clear_string();
        end
    endfunction

    function automatic void flag_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns checker: %s", $time, what);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            clear_string();
            min_len    = MIN_LEN_RST;
            max_len    = MAX_LEN_RST;
            owed_verdicts.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_LENGTH) begin
                    min_len = i_cfg_data;
                end else if (i_cfg_idx == CFG_MAX_LENGTH) begin
                    max_len = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_verdicts.size() == 0) begin
                    flag_failure($sformatf("result beat with none owed: valid %0b code %0d len %0d",
                                           i_out_beat.valid_res, i_out_beat.error_code,
                                           i_out_beat.kept_length));
                end else begin
                    want = owed_verdicts.pop_front();
                    if (i_out_beat.valid_res !== want.valid_res ||
                        i_out_beat.error_code !== want.error_code ||
                        i_out_beat.kept_length !== want.kept_length) begin
                        flag_failure($sformatf({"result mismatch: valid exp %0b got %0b, ",
                                                "code exp %0d got %0d, len exp %0d got %0d"},
                                               want.valid_res, i_out_beat.valid_res,
                                               want.error_code, i_out_beat.error_code,
                                               want.kept_length, i_out_beat.kept_length));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_char(i_in_beat);
            end
        end
        owed_cnt = owed_verdicts.size();
    end

endmodule

// ===== test/tb_iban_checksum_validator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iban_checksum_validator_core
// Stimulus and verdict for the streaming IBAN validator. Sends short
// hand-picked strings first, then mostly well-formed IBANs with correct
// check digits, some spoiled ones and some byte noise, under several
// length windows. The checker module beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb_iban_checksum_validator_core;
    import icv_pkg::*;

    // cycles without any beat before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;
    // settling margin once every owed result is out
    localparam int SETTLE_CYCLES  = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_beat              in_beat;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int                    burst_left;
    int                    beats_sent;
    int                    idle_cycles;
    int                    ready_mode;
    int                    mode_left = 0;
    logic [LEN_W-1:0]      cur_min;
    logic [LEN_W-1:0]      cur_max;
    // the string being sent, without separators
    logic [CHAR_W-1:0]     iban_chars [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    iban_checksum_validator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    iban_checksum_validator_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (out_beat),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side stalls on its own schedule: a mode is held for a while,
    // from always ready to mostly stalled
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
        end
        mode_left--;
        case (ready_mode)
            0: begin
                out_ready <= 1'b1;
            end
            1: begin
                out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_ready <= $urandom_range(0, 7) != 0;
            end
            default: begin
                out_ready <= $urandom_range(0, 15) == 0;
            end
        endcase
    end

    // watchdog: any accepted beat on either channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // digit value 0..9 or letter value 10..35 as ascii, letter case chosen
    function automatic logic [CHAR_W-1:0] alnum_char(input int v, input bit lower);
        if (v < 10) begin
            return CHR_ZERO + CHAR_W'(v);
        end
        return (lower ? CHR_LO_A : CHR_UP_A) + CHAR_W'(v - 10);
    endfunction

    function automatic int mod97_digits(input int r, input int v);
        return (v >= 10 ? r * 100 + v : r * 10 + v) % 97;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_separator();
        return $urandom_range(0, 1) ? CHR_SPACE : CHR_DASH;
    endfunction

    // well-formed iban: country, check digits, body of the given length
    function automatic void build_iban(input int body_len);
        int                rem;
        int                cd;
        int                c1;
        int                c2;
        int                v;
        bit                lc;
        logic [CHAR_W-1:0] body [$];
        rem = 0;
        lc  = $urandom_range(0, 3) == 0;
        for (int i = 0; i < body_len; i++) begin
            v   = $urandom_range(0, 3) == 0 ? $urandom_range(10, 35) : $urandom_range(0, 9);
            rem = mod97_digits(rem, v);
            body.push_back(alnum_char(v, lc || $urandom_range(0, 7) == 0));
        end
        c1  = $urandom_range(10, 35);
        c2  = $urandom_range(10, 35);
        rem = mod97_digits(rem, c1);
        rem = mod97_digits(rem, c2);
        rem = mod97_digits(rem, 0);
        rem = mod97_digits(rem, 0);
        cd  = 98 - rem;
        iban_chars = {alnum_char(c1, lc), alnum_char(c2, lc),
                      alnum_char(cd / 10, 1'b0), alnum_char(cd % 10, 1'b0)};
        foreach (body[i]) begin
            iban_chars.push_back(body[i]);
        end
    endfunction

    // break a well-formed iban in one of several ways
    function automatic void spoil_iban();
        int                p;
        logic [CHAR_W-1:0] t;
        if (iban_chars.size() < 2) begin
            return;
        end
        p = $urandom_range(0, iban_chars.size() - 2);
        case ($urandom_range(0, 3))
            0: begin
                iban_chars[p] = alnum_char($urandom_range(0, 35), 1'($urandom_range(0, 1)));
            end
            1: begin
                iban_chars.insert(p, CHAR_W'($urandom_range(0, 255)));
            end
            2: begin
                iban_chars[$urandom_range(0, 1)] = alnum_char($urandom_range(0, 9), 1'b0);
            end
            default: begin
                t                 = iban_chars[p];
                iban_chars[p]     = iban_chars[p + 1];
                iban_chars[p + 1] = t;
            end
        endcase
    endfunction

    // one character beat; the sender works in bursts with gaps between them
    task automatic send_beat(input logic [CHAR_W-1:0] c, input logic lst);
        int   gap;
        logic acc;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long burst with no gaps at all
            burst_left = $urandom_range(0, 5) == 0 ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_beat  <= '{char_code: c, last: lst};
        // nothing moves between falling and rising edge, so the handshake
        // seen at the falling edge is the one taken at the next rising edge
        do begin
            @(negedge i_clk);
            acc = in_ready;
            @(posedge i_clk);
        end while (!acc);
        beats_sent++;
    endtask

    // send the held string, maybe in groups of four, maybe closed by a separator
    task automatic send_text();
        int  n;
        bit  grouped;
        bit  tail_sep;
        n        = iban_chars.size();
        grouped  = $urandom_range(0, 2) == 0;
        tail_sep = n == 0 || $urandom_range(0, 7) == 0;
        for (int i = 0; i < n; i++) begin
            if (grouped && i > 0 && i % 4 == 0) begin
                send_beat(pick_separator(), 1'b0);
            end
            send_beat(iban_chars[i], i == n - 1 && !tail_sep);
        end
        if (tail_sep) begin
            send_beat(pick_separator(), 1'b1);
        end
    endtask

    // sender pauses until every owed result is out and the pipe is quiet
    task automatic wait_for_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called while idle; back to back writes keep the enable high
    task automatic set_lengths(input int min_v, input int max_v);
        cur_min  = LEN_W'(min_v);
        cur_max  = LEN_W'(max_v);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MIN_LENGTH;
        cfg_data <= CFG_DATA_W'(min_v);
        @(posedge i_clk);
        cfg_idx  <= CFG_MAX_LENGTH;
        cfg_data <= CFG_DATA_W'(max_v);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic directed_strings();
        // empty string: only a separator, which closes it
        send_beat(CHR_DASH, 1'b1);
        // single letter, too short for a country
        send_beat(CHR_UP_A, 1'b1);
        // letter extremes in both cases, no check digits
        send_beat(CHR_LO_Z, 1'b0);
        send_beat(CHR_UP_Z, 1'b1);
        // digit in the country field
        send_beat(CHR_NINE, 1'b0);
        send_beat(CHR_LO_A, 1'b1);
        // codes above ascii and code zero are illegal
        send_beat(CHR_UP_A + 8'd6, 1'b0);
        send_beat(CHR_UP_A + 8'd1, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        // shortest well-formed iban, then one with a small body
        build_iban(0);
        send_text();
        build_iban(3);
        send_text();
    endtask

    // random strings until roughly beat_goal beats have gone out
    task automatic random_strings(input int beat_goal);
        int start;
        int kind;
        int target;
        int lo;
        int hi;
        start = beats_sent;
        while (beats_sent - start < beat_goal) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                // byte noise, any code, any length up to a dozen
                iban_chars.delete();
                repeat ($urandom_range(0, 12)) begin
                    iban_chars.push_back(CHAR_W'($urandom_range(0, 255)));
                end
            end else begin
                lo = int'(cur_min) - 2;
                hi = int'(cur_max) + 2;
                if (lo < 0) begin
                    lo = 0;
                end
                if (hi > 63) begin
                    hi = 63;
                end
                if ($urandom_range(0, 29) == 0) begin
                    // up to and past the count ceiling
                    target = $urandom_range(60, 75);
                end else if (lo <= hi) begin
                    target = $urandom_range(lo, hi);
                end else begin
                    target = $urandom_range(0, 40);
                end
                if (target >= 4) begin
                    build_iban(target - 4);
                    if (kind >= 14) begin
                        spoil_iban();
                    end
                end else begin
                    iban_chars.delete();
                    repeat (target) begin
                        iban_chars.push_back(alnum_char($urandom_range(0, 35), 1'b0));
                    end
                end
            end
            send_text();
            if ($urandom_range(0, 39) == 0) begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        in_valid   = 1'b0;
        in_beat    = '0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_MIN_LENGTH;
        cfg_data   = '0;
        burst_left = 0;
        beats_sent = 0;
        cur_min    = MIN_LEN_RST;
        cur_max    = MAX_LEN_RST;
        i_rst_n    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // widest window so the short hand-picked strings reach every check
        set_lengths(0, 63);
        directed_strings();
        wait_for_results();

        // reset window, then the extremes, an inverted window and two others
        set_lengths(15, 34);
        random_strings(450);
        wait_for_results();
        set_lengths(0, 0);
        random_strings(80);
        wait_for_results();
        set_lengths(63, 63);
        random_strings(200);
        wait_for_results();
        set_lengths(40, 10);
        random_strings(100);
        wait_for_results();
        set_lengths(5, 24);
        random_strings(300);
        wait_for_results();
        set_lengths(10, 45);
        random_strings(350);
        wait_for_results();

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/icv_pkg.sv
design/icv_string_acc.sv
design/iban_checksum_validator_core.sv
test/iban_checksum_validator_checker.sv
test/tb_iban_checksum_validator_core.sv
